// File: sv/tec_pkg.sv
`default_nettype none
package tec_pkg;

    typedef logic [1:0] t_enc_code;

    localparam t_enc_code ENC_ANSI    = 2'd0;
    localparam t_enc_code ENC_UTF16LE = 2'd1;
    localparam t_enc_code ENC_UTF8    = 2'd2;
    localparam t_enc_code ENC_BINARY  = 2'd3;

    localparam logic [15:0] BOM_UTF16LE    = 16'hFEFF;
    localparam logic [15:0] BOM_UTF8_LOW   = 16'hBBEF;
    localparam logic [7:0]  BOM_UTF8_HIGH  = 8'hBF;
    localparam logic [7:0]  BYTE_C0        = 8'hC0;
    localparam logic [7:0]  BYTE_C1        = 8'hC1;
    localparam logic [7:0]  BYTE_F5        = 8'hF5;

    // utf8 lead classes (masked compares)
    localparam logic [7:0]  LEAD2_MASK     = 8'hE0;
    localparam logic [7:0]  LEAD2_VAL      = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD3_VAL      = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK     = 8'hF8;
    localparam logic [7:0]  LEAD4_VAL      = 8'hF0;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_VAL       = 8'h80;

    localparam logic [2:0]  COUNT_MAX      = 3'd7;

endpackage
`default_nettype wire

// File: sv/text_encoding_classifier.sv
// path: a buffer's last byte passes the input register, then its code is registered for o_valid
// throughput: one byte per cycle; a byte holds in the input register only while the
//   code of a finished buffer waits in the output register and i_stall is high
// reset: i_rst_n synchronous active low clears both stage valids and all buffer state;
//   the state also returns to its reset value after every last byte
`default_nettype none
module text_encoding_classifier
    import tec_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    output logic            o_stall,
    output logic            o_valid,
    output logic [1:0]      o_encoding_code,
    input  wire logic       i_stall
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // buffer state
    logic [2:0]  r_byte_count,   n_byte_count;
    logic        r_length_odd,   n_length_odd;
    logic [23:0] r_leading,      n_leading;
    logic [7:0]  r_pending,      n_pending;
    logic        r_zero_word,    n_zero_word;
    logic        r_last_wzero,   n_last_wzero;
    logic        r_zero_byte,    n_zero_byte;
    logic        r_illegal,      n_illegal;
    logic [1:0]  r_cont_exp,     n_cont_exp;
    logic [11:0] r_lead_win,     n_lead_win;
    logic        r_mb_ok,        n_mb_ok;
    logic        r_mb_bad,       n_mb_bad;

    // result register
    logic       r_out_valid;
    t_enc_code  r_out_code;
    t_enc_code  n_code;

    logic       out_free;
    logic       s1_go;
    logic       take_in;
    logic       is_cont;
    logic [3:0] retired;
    logic [2:0] verdict;
    logic [1:0] lead_len;
    logic [7:0] b;

    assign out_free = !r_out_valid || !i_stall;
    // a byte that does not end the buffer never needs the output register
    assign s1_go    = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !s1_go;
    assign take_in  = i_valid && !o_stall;

    assign o_valid         = r_out_valid;
    assign o_encoding_code = r_out_code;

    assign b       = r_in_byte;
    assign is_cont = (b & CONT_MASK) == CONT_VAL;

    always_comb begin
        n_byte_count = (r_byte_count < COUNT_MAX) ? r_byte_count + 3'd1 : COUNT_MAX;
        n_leading    = r_leading;
        case (r_byte_count)
            3'd0:    n_leading[7:0]   = b;
            3'd1:    n_leading[15:8]  = b;
            3'd2:    n_leading[23:16] = b;
            default: n_leading        = r_leading;
        endcase
        n_zero_byte  = r_zero_byte || (r_byte_count >= 3'd2 && b == 8'd0);
        n_illegal    = r_illegal || b == BYTE_C0 || b == BYTE_C1 || b >= BYTE_F5;
        n_pending    = r_pending;
        n_zero_word  = r_zero_word;
        n_last_wzero = r_last_wzero;
        if (!r_length_odd) begin
            n_pending = b;
        end else begin
            n_zero_word  = r_zero_word | r_last_wzero;
            n_last_wzero = (r_pending == 8'd0) && (b == 8'd0);
        end
        n_length_odd = ~r_length_odd;

        // utf8 sequence tracking over a three-byte window of lead slots
        retired    = r_lead_win[11:8];
        n_lead_win = {r_lead_win[7:0], 4'b0000};
        n_cont_exp = r_cont_exp;
        verdict    = 3'b000;
        lead_len   = 2'd0;
        if (r_cont_exp != 2'd0) begin
            if (is_cont) begin
                n_cont_exp = r_cont_exp - 2'd1;
                if (r_cont_exp == 2'd1) begin
                    verdict = 3'b010;
                end
            end else begin
                n_cont_exp = 2'd0;
                verdict    = 3'b100;
            end
            if (verdict != 3'b000) begin
                if (n_lead_win[4]) begin
                    n_lead_win[6:4] = n_lead_win[6:4] | verdict;
                end else if (n_lead_win[8]) begin
                    n_lead_win[10:8] = n_lead_win[10:8] | verdict;
                end else begin
                    retired[2:0] = retired[2:0] | verdict;
                end
            end
        end else begin
            if ((b & LEAD2_MASK) == LEAD2_VAL) begin
                lead_len = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
                lead_len = 2'd2;
            end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
                lead_len = 2'd3;
            end
            if (lead_len != 2'd0) begin
                n_lead_win[0] = 1'b1;
                n_cont_exp    = lead_len;
            end
        end
        n_mb_ok  = r_mb_ok  | retired[1];
        n_mb_bad = r_mb_bad | retired[2];

        if (n_byte_count < 3'd2) begin
            n_code = ENC_ANSI;
        end else if (n_zero_word || (n_length_odd && n_last_wzero)) begin
            n_code = ENC_BINARY;
        end else if (n_zero_byte && !n_length_odd) begin
            n_code = ENC_UTF16LE;
        end else if (n_leading[15:0] == BOM_UTF16LE) begin
            n_code = ENC_UTF16LE;
        end else if (n_byte_count < 3'd3) begin
            n_code = ENC_ANSI;
        end else if (n_leading[15:0] == BOM_UTF8_LOW && n_leading[23:16] == BOM_UTF8_HIGH) begin
            n_code = ENC_UTF8;
        end else if (n_illegal || n_mb_bad) begin
            n_code = ENC_ANSI;
        end else if (n_mb_ok) begin
            n_code = ENC_UTF8;
        end else begin
            n_code = ENC_ANSI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
        if (take_in) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_in_last)) begin
            r_byte_count <= 3'd0;
            r_length_odd <= 1'b0;
            r_leading    <= 24'd0;
            r_pending    <= 8'd0;
            r_zero_word  <= 1'b0;
            r_last_wzero <= 1'b0;
            r_zero_byte  <= 1'b0;
            r_illegal    <= 1'b0;
            r_cont_exp   <= 2'd0;
            r_lead_win   <= 12'd0;
            r_mb_ok      <= 1'b0;
            r_mb_bad     <= 1'b0;
        end else if (s1_go) begin
            r_byte_count <= n_byte_count;
            r_length_odd <= n_length_odd;
            r_leading    <= n_leading;
            r_pending    <= n_pending;
            r_zero_word  <= n_zero_word;
            r_last_wzero <= n_last_wzero;
            r_zero_byte  <= n_zero_byte;
            r_illegal    <= n_illegal;
            r_cont_exp   <= n_cont_exp;
            r_lead_win   <= n_lead_win;
            r_mb_ok      <= n_mb_ok;
            r_mb_bad     <= n_mb_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_go && r_in_last) begin
            r_out_code <= n_code;
        end
    end

endmodule
`default_nettype wire
